// ===== design/psfl_pkg.sv =====
// ----------------------------------------------------------------------------
// psfl_pkg: shared types and constants for the serial PLL frequency loader
// Transaction payload structs, status codes and the fixed frequency plan.
// ----------------------------------------------------------------------------
package psfl_pkg;

  localparam int unsigned OFFSET_W  = 26;
  localparam int unsigned CHANNEL_W = 14;
  localparam int unsigned HALF_W    = 8;
  localparam int unsigned BIT_W     = 5;

  localparam int unsigned BASE_HZ         = 70000000;
  localparam int unsigned MAX_HZ          = 120000000;
  localparam int unsigned CHANNEL_STEP_HZ = 10000;
  localparam int unsigned OFFSET_MAX      = MAX_HZ - BASE_HZ;
  localparam int unsigned CHANNEL_BASE    = BASE_HZ / CHANNEL_STEP_HZ;

  // Reciprocal of the channel step, exact for every offset up to OFFSET_MAX.
  localparam int unsigned RECIP_SHIFT = 39;
  localparam int unsigned RECIP_MULT  = 54975582;
  localparam int unsigned PROD_W      = 2 * OFFSET_W;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 8'd20;
  localparam logic [BIT_W-1:0]  SLOTS_PER_FRAME   = 5'd18;

  localparam logic [15:0] WORD_B_FIRST  = 16'hdd05;
  localparam logic [15:0] WORD_B_MIDDLE = 16'hdd85;
  localparam logic [15:0] WORD_B_LAST   = 16'hc385;

  typedef enum logic [1:0] {
    STATUS_TICK     = 2'd0,
    STATUS_ACCEPTED = 2'd1,
    STATUS_RANGE    = 2'd2,
    STATUS_BUSY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PRE   = 3'b010,
    PH_FRAME = 3'b100
  } phase_e;

  typedef struct packed {
    logic                func;
    logic [OFFSET_W-1:0] freq_offset_hz;
  } in_item_t;

  typedef struct packed {
    logic    latch_enable;
    logic    serial_clock;
    logic    serial_data;
    logic    busy_res;
    status_e request_status;
  } out_item_t;

endpackage

// ===== design/pll_serial_frequency_load.sv =====
// ----------------------------------------------------------------------------
// pll_serial_frequency_load: tick-driven three-wire PLL word loader
// Turns a frequency request into a channel word and plays the pin sequence.
// ----------------------------------------------------------------------------
// Each input transaction is either a tick or a set-frequency request. Every
// accepted input transaction produces exactly one output transaction that
// carries the latch, clock and data pin levels after that item, a busy flag
// and the request status.
// The result is registered: it appears in the cycle after acceptance, and a
// new input transaction can be accepted in every cycle while the receiver
// takes each result, so the sustained rate is then one item per cycle. The
// state update and the channel word computation (one 26 by 26 bit reciprocal
// multiply) sit between the input port and the output register.
// When the receiver stalls, the result is held and in_ready_o stays high only
// if the held result is taken in the same cycle.
// Reset clears the sequencer to idle with all pins low and sets the half
// period register to 20 ticks. The half period register is written through cfg_we_i and
// cfg_wdata_i; the user must write it only with no transaction in flight, which the block
// does not enforce, and a new value takes effect at the start of the next clock half.
// ----------------------------------------------------------------------------
module pll_serial_frequency_load #(
  parameter int unsigned PREAMBLE_PULSES = 14,
  parameter int unsigned MIDDLE_REPEATS  = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psfl_pkg::HALF_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psfl_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output psfl_pkg::out_item_t             out_data_o
);

  localparam int unsigned Frames = 2 * (MIDDLE_REPEATS + 2);
  localparam int unsigned WordW  = $clog2(Frames + 1);

  localparam logic [WordW-1:0]          FramesW  = WordW'(Frames);
  localparam logic [WordW-2:0]          LastPair = (WordW-1)'(MIDDLE_REPEATS + 1);
  localparam logic [psfl_pkg::BIT_W-1:0] PreW    = psfl_pkg::BIT_W'(PREAMBLE_PULSES);

  logic [psfl_pkg::HALF_W-1:0]    half_period_q;
  psfl_pkg::phase_e               phase_q, phase_d;
  logic [WordW-1:0]               word_q, word_d;
  logic [psfl_pkg::BIT_W-1:0]     bit_q, bit_d;
  logic [psfl_pkg::HALF_W-1:0]    timer_q, timer_d;
  logic                           high_q, high_d;
  logic [psfl_pkg::CHANNEL_W-1:0] chan_q, chan_d;
  logic                           latch_q, latch_d;
  logic                           sclk_q, sclk_d;
  logic                           sdata_q, sdata_d;
  logic                           out_valid_q;
  psfl_pkg::out_item_t            out_q, out_d;

  logic                           accept;
  logic [psfl_pkg::HALF_W-1:0]    half_len;
  logic [psfl_pkg::PROD_W-1:0]    product;
  logic [psfl_pkg::CHANNEL_W-1:0] chan_calc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign half_len  = (half_period_q == '0) ? psfl_pkg::HALF_W'(1) : half_period_q;
  assign product   = psfl_pkg::PROD_W'(in_data_i.freq_offset_hz)
                   * psfl_pkg::PROD_W'(psfl_pkg::RECIP_MULT);
  assign chan_calc = psfl_pkg::CHANNEL_W'(psfl_pkg::CHANNEL_BASE)
                   + psfl_pkg::CHANNEL_W'(product >> psfl_pkg::RECIP_SHIFT);

  always_comb begin
    logic                        do_start;
    logic [psfl_pkg::HALF_W-1:0] t;
    logic [15:0]                 fword;
    logic [psfl_pkg::BIT_W-1:0]  pos_full;
    logic [3:0]                  pos;
    psfl_pkg::status_e           status;

    phase_d  = phase_q;
    word_d   = word_q;
    bit_d    = bit_q;
    timer_d  = timer_q;
    high_d   = high_q;
    chan_d   = chan_q;
    latch_d  = latch_q;
    sclk_d   = sclk_q;
    sdata_d  = sdata_q;
    do_start = 1'b0;
    status   = psfl_pkg::STATUS_TICK;
    t        = timer_q;
    fword    = '0;
    pos_full = '0;
    pos      = '0;

    if (accept) begin
      if (!in_data_i.func) begin
        if (phase_q != psfl_pkg::PH_IDLE) begin
          if (t != '0) begin
            t = t - 1'b1;
          end
          timer_d = t;
          if (t == '0) begin
            if (high_q) begin
              high_d  = 1'b0;
              sclk_d  = 1'b0;
              timer_d = half_len;
            end else if (phase_q == psfl_pkg::PH_PRE) begin
              bit_d    = bit_q + 1'b1;
              do_start = 1'b1;
              if (bit_d >= PreW) begin
                phase_d = psfl_pkg::PH_FRAME;
                word_d  = '0;
                bit_d   = '0;
              end
            end else begin
              bit_d    = bit_q + 1'b1;
              do_start = 1'b1;
              if (bit_d >= psfl_pkg::SLOTS_PER_FRAME) begin
                bit_d  = '0;
                word_d = word_q + 1'b1;
                if (word_d >= FramesW) begin
                  phase_d  = psfl_pkg::PH_IDLE;
                  word_d   = '0;
                  do_start = 1'b0;
                end
              end
            end
          end
        end
      end else if (phase_q != psfl_pkg::PH_IDLE) begin
        status = psfl_pkg::STATUS_BUSY;
      end else if (in_data_i.freq_offset_hz > psfl_pkg::OFFSET_W'(psfl_pkg::OFFSET_MAX)) begin
        status = psfl_pkg::STATUS_RANGE;
      end else begin
        status   = psfl_pkg::STATUS_ACCEPTED;
        chan_d   = chan_calc;
        word_d   = '0;
        bit_d    = '0;
        phase_d  = (PREAMBLE_PULSES == 0) ? psfl_pkg::PH_FRAME : psfl_pkg::PH_PRE;
        do_start = 1'b1;
      end
    end

    if (word_d[0]) begin
      fword = 16'(chan_d);
    end else if (word_d[WordW-1:1] == '0) begin
      fword = psfl_pkg::WORD_B_FIRST;
    end else if (word_d[WordW-1:1] == LastPair) begin
      fword = psfl_pkg::WORD_B_LAST;
    end else begin
      fword = psfl_pkg::WORD_B_MIDDLE;
    end
    pos_full = psfl_pkg::BIT_W'(16) - bit_d;
    pos      = pos_full[3:0];

    if (do_start) begin
      if (phase_d == psfl_pkg::PH_FRAME) begin
        if (bit_d == '0) begin
          latch_d = 1'b1;
          sdata_d = 1'b0;
        end else if (bit_d >= psfl_pkg::SLOTS_PER_FRAME - 1'b1) begin
          latch_d = 1'b0;
          sdata_d = 1'b0;
        end else begin
          latch_d = 1'b1;
          if (pos == 4'd15) begin
            sdata_d = !word_d[0];
          end else begin
            sdata_d = fword[pos];
          end
        end
      end
      sclk_d  = 1'b1;
      high_d  = 1'b1;
      timer_d = half_len;
    end

    out_d.latch_enable   = latch_d;
    out_d.serial_clock   = sclk_d;
    out_d.serial_data    = sdata_d;
    out_d.busy_res       = (phase_d != psfl_pkg::PH_IDLE);
    out_d.request_status = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= psfl_pkg::HALF_PERIOD_RESET;
      phase_q       <= psfl_pkg::PH_IDLE;
      word_q        <= '0;
      bit_q         <= '0;
      timer_q       <= '0;
      high_q        <= 1'b0;
      chan_q        <= '0;
      latch_q       <= 1'b0;
      sclk_q        <= 1'b0;
      sdata_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_period_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      word_q  <= word_d;
      bit_q   <= bit_d;
      timer_q <= timer_d;
      high_q  <= high_d;
      chan_q  <= chan_d;
      latch_q <= latch_d;
      sclk_q  <= sclk_d;
      sdata_q <= sdata_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/psfl_checker.sv =====
// ----------------------------------------------------------------------------
// psfl_checker: port-level checks for the serial PLL frequency loader
// Watches the transaction ports and the pin levels reported in results.
// ----------------------------------------------------------------------------
module psfl_checker (
  input logic                rst_ni,
  input logic                clk_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input psfl_pkg::out_item_t out_data_o
);

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // With no result pending the input side is never blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // An accepted request starts a sequence with the clock high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.request_status == psfl_pkg::STATUS_ACCEPTED
    |-> out_data_o.busy_res && out_data_o.serial_clock)
    else $error("accepted request did not start the sequence");

  // A busy rejection is only reported while a sequence is playing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.request_status == psfl_pkg::STATUS_BUSY
    |-> out_data_o.busy_res)
    else $error("busy rejection while idle");

  // While idle the clock and latch pins rest low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res
    |-> !out_data_o.serial_clock && !out_data_o.latch_enable)
    else $error("pins not at rest while idle");

endmodule

bind pll_serial_frequency_load psfl_checker u_psfl_checker (
  .rst_ni      (rst_ni),
  .clk_i       (clk_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
